@@ design/fhfa_pkg.sv @@
package fhfa_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef enum logic [1:0] {
		STAT_ALLOC   = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_WRITTEN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_BASE,
		S_UPD,
		S_RESP
	} state_t;

	typedef struct packed {
		logic size_rd;
		logic base_rd;
		logic size_we;
		logic base_we;
	} store_ctl_t;

endpackage

@@ design/fhfa_hole_store.sv @@
module fhfa_hole_store #(
	parameter int MAX_HOLES    = 16,
	parameter int ADDRESS_BITS = 16,
	parameter int IDX_W        = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fhfa_pkg::store_ctl_t      ctl,
	input  logic [IDX_W-1:0]          rd_addr,
	input  logic [IDX_W-1:0]          wr_addr,
	input  logic [ADDRESS_BITS-1:0]   wr_base,
	input  logic [ADDRESS_BITS-1:0]   wr_size,
	output logic [ADDRESS_BITS-1:0]   rd_base,
	output logic [ADDRESS_BITS-1:0]   rd_size
);
	import fhfa_pkg::*;

	logic [ADDRESS_BITS-1:0] base_mem [MAX_HOLES];
	logic [ADDRESS_BITS-1:0] size_mem [MAX_HOLES];
	logic [MAX_HOLES-1:0]    valid_q;
	logic [ADDRESS_BITS-1:0] base_q;
	logic [ADDRESS_BITS-1:0] size_q;
	logic                    size_vld_q;

	// Sizes read as zero until their entry has been written once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.size_we) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.size_we) begin
			size_mem[wr_addr] <= wr_size;
		end
		if (ctl.size_rd) begin
			size_q     <= size_mem[rd_addr];
			size_vld_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.base_we) begin
			base_mem[wr_addr] <= wr_base;
		end
		if (ctl.base_rd) begin
			base_q <= base_mem[rd_addr];
		end
	end

	assign rd_base = base_q;
	assign rd_size = size_vld_q ? size_q : '0;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.size_we && (ctl.size_rd || ctl.base_rd)))
		else $error("hole store read and write in the same cycle");

	a_paired_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.size_we == ctl.base_we)
		else $error("base and size writes not paired");

	a_single_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.size_rd && ctl.base_rd))
		else $error("size and base read together");

endmodule

@@ design/free_hole_fit_allocator_core.sv @@
// Channel  Direction  Handshake            Payload
// s        in         s_tvalid/s_tready    tuser opcode; tdata entry, base, size, request
// m        out        m_tvalid/m_tready    tuser status; tdata base, limit, chosen hole
// cfg      in         cfg_valid/cfg_ready  cfg_data fit policy
//
// A hole write goes straight to the response state after its transfer; an allocation first
// scans the size memory one entry per cycle through its single read port, then reads the
// base and writes it back. A new transfer is taken only once the block is idle again.
// A waiting result does not block the next transfer in, but the next
// result holds the block until the output register is free.
// Reset clears the control state, the policy and every size entry at once.
module free_hole_fit_allocator_core #(
	parameter int MAX_HOLES    = 16,
	parameter int ADDRESS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // entry_index, hole_base, hole_size, request_size
	input  logic [0:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // segment_base, segment_limit, chosen_hole
	output logic [1:0]  m_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import fhfa_pkg::*;

	localparam int IDX_W = $clog2(MAX_HOLES);
	localparam int AW    = ADDRESS_BITS;
	localparam int CMP_W = (AW > 16) ? AW : 16;
	localparam int SUM_W = CMP_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_HOLES - 1);

	state_t              state_q, state_d;
	store_ctl_t          ctl;
	logic [1:0]          policy_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [15:0]         need_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                found_q;
	logic [IDX_W-1:0]    pick_q;
	logic [AW-1:0]       best_sz_q;
	status_t             res_status_q;
	logic [15:0]         res_base_q;
	logic [16:0]         res_limit_q;
	logic [3:0]          res_hole_q;
	logic                m_tvalid_q;
	logic [39:0]         m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic [3:0]          in_entry;
	logic [15:0]         in_base;
	logic [15:0]         in_size;
	logic [15:0]         in_req;
	logic                s_xfer;
	logic                in_range;
	logic                out_free;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [AW-1:0]       wr_base;
	logic [AW-1:0]       wr_size;
	logic [AW-1:0]       rd_base;
	logic [AW-1:0]       rd_size;
	logic                fits;
	logic                take;
	logic [SUM_W-1:0]    sum;

	assign in_entry = s_tdata[3:0];
	assign in_base  = s_tdata[19:4];
	assign in_size  = s_tdata[35:20];
	assign in_req   = s_tdata[51:36];
	assign s_xfer   = s_tvalid && s_tready;
	assign in_range = (32'(in_entry) < MAX_HOLES);
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	fhfa_hole_store #(
		.MAX_HOLES    (MAX_HOLES),
		.ADDRESS_BITS (ADDRESS_BITS),
		.IDX_W        (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_base (wr_base),
		.wr_size (wr_size),
		.rd_base (rd_base),
		.rd_size (rd_size)
	);

	assign fits = (rd_size != '0) && (CMP_W'(rd_size) >= CMP_W'(need_q));
	assign take = fits && (!found_q
		|| ((policy_q == POL_BEST) && (rd_size < best_sz_q))
		|| ((policy_q == POL_WORST) && (rd_size > best_sz_q)));
	assign sum = SUM_W'(rd_base) + SUM_W'(need_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser[0] == OP_ALLOC) ? S_SCAN : S_RESP;
				end
			end
			S_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = S_FIN;
				end
			end
			S_FIN:  state_d = S_BASE;
			S_BASE: state_d = S_UPD;
			S_UPD:  state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		ctl         = '0;
		rd_addr     = cnt_q;
		wr_addr     = pick_q;
		wr_base     = AW'(sum);
		wr_size     = best_sz_q - AW'(need_q);
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				wr_addr     = IDX_W'(in_entry);
				wr_base     = AW'(in_base);
				wr_size     = AW'(in_size);
				ctl.size_we = s_tvalid && (s_tuser[0] == OP_WRITE) && in_range;
				ctl.base_we = s_tvalid && (s_tuser[0] == OP_WRITE) && in_range;
			end
			S_SCAN: begin
				ctl.size_rd = 1'b1;
			end
			S_BASE: begin
				rd_addr     = pick_q;
				ctl.base_rd = found_q;
			end
			S_UPD: begin
				ctl.size_we = found_q;
				ctl.base_we = found_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			policy_q   <= POL_FIRST;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_SCAN);
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end
			if (s_xfer) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (state_q == S_SCAN) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (rd_vld_s1 && take) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == S_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (s_xfer) begin
			need_q       <= in_req;
			res_status_q <= STAT_WRITTEN;
			res_base_q   <= '0;
			res_limit_q  <= '0;
			res_hole_q   <= '0;
		end
		if (rd_vld_s1 && take) begin
			pick_q    <= rd_idx_s1;
			best_sz_q <= rd_size;
		end
		if (state_q == S_UPD) begin
			if (found_q) begin
				res_status_q <= STAT_ALLOC;
				res_base_q   <= 16'(rd_base);
				res_limit_q  <= 17'(sum);
				res_hole_q   <= 4'(pick_q);
			end else begin
				res_status_q <= STAT_NOFIT;
			end
		end
		if (state_q == S_RESP && out_free) begin
			m_tdata_q <= {3'b000, res_hole_q, res_limit_q, res_base_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.size_we |-> (state_q == S_IDLE || state_q == S_UPD))
		else $error("hole store written outside idle or update");

	a_compare_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN || state_q == S_FIN))
		else $error("size compare outside the scan");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && found_q) |-> (best_sz_q != '0))
		else $error("chosen hole is empty");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q != STAT_ALLOC) |-> (m_tdata_q == '0))
		else $error("nonzero fields on a result without allocation");

endmodule
